### hdl/xenc_pkg.sv
// Shared types, codes and decode tables for the exception nesting classifier.
`timescale 1ns / 1ps
`default_nettype none

package xenc_pkg;

  localparam int unsigned VecW    = 5;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned FamilyW = 3;
  localparam int unsigned CountW  = 2;

  localparam logic [FamilyW-1:0] FAMILY_RESET = 3'd6;
  localparam logic [FamilyW-1:0] FAMILY_AC    = 3'd4;
  localparam logic [FamilyW-1:0] FAMILY_MC    = 3'd5;
  localparam logic [FamilyW-1:0] FAMILY_XM    = 3'd6;

  localparam logic [CountW-1:0] COUNT_MAX = 2'd3;
  localparam logic [CountW-1:0] COUNT_TWO = 2'd2;

  localparam logic [VecW-1:0] VEC_DE  = 5'd0;
  localparam logic [VecW-1:0] VEC_DB  = 5'd1;
  localparam logic [VecW-1:0] VEC_NMI = 5'd2;
  localparam logic [VecW-1:0] VEC_BP  = 5'd3;
  localparam logic [VecW-1:0] VEC_OF  = 5'd4;
  localparam logic [VecW-1:0] VEC_BR  = 5'd5;
  localparam logic [VecW-1:0] VEC_UD  = 5'd6;
  localparam logic [VecW-1:0] VEC_NM  = 5'd7;
  localparam logic [VecW-1:0] VEC_DF  = 5'd8;
  localparam logic [VecW-1:0] VEC_TS  = 5'd10;
  localparam logic [VecW-1:0] VEC_NP  = 5'd11;
  localparam logic [VecW-1:0] VEC_SS  = 5'd12;
  localparam logic [VecW-1:0] VEC_GP  = 5'd13;
  localparam logic [VecW-1:0] VEC_PF  = 5'd14;
  localparam logic [VecW-1:0] VEC_MF  = 5'd16;
  localparam logic [VecW-1:0] VEC_AC  = 5'd17;
  localparam logic [VecW-1:0] VEC_MC  = 5'd18;
  localparam logic [VecW-1:0] VEC_XM  = 5'd19;

  typedef enum logic {
    OP_RAISE    = 1'b0,
    OP_COMPLETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DELIVER = 2'd0,
    STATUS_TRIPLE  = 2'd1,
    STATUS_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CLS_BENIGN  = 2'd0,
    CLS_CONTRIB = 2'd1,
    CLS_PAGE    = 2'd2,
    CLS_DOUBLE  = 2'd3
  } class_e;

  // row: previous class, bit: current class
  localparam logic [3:0] PROMOTE [4] = '{4'b1000, 4'b1010, 4'b1110, 4'b1111};

  typedef struct packed {
    op_e              op;
    logic [VecW-1:0]  vector;
    logic [CodeW-1:0] code;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic [VecW-1:0]  vector;
    logic             push;
    logic [CodeW-1:0] code;
    logic             restart;
  } result_t;

  typedef struct packed {
    logic known;
    logic push;
    logic zero_code;
    logic restart;
  } vec_info_t;

  function automatic class_e vec_class(input logic [VecW-1:0] vec);
    class_e cls;
    cls = CLS_BENIGN;
    case (vec) inside
      VEC_DE, VEC_TS, VEC_NP, VEC_SS, VEC_GP: cls = CLS_CONTRIB;
      VEC_PF:                                 cls = CLS_PAGE;
      VEC_DF:                                 cls = CLS_DOUBLE;
      default:                                cls = CLS_BENIGN;
    endcase
    return cls;
  endfunction

  function automatic vec_info_t vec_decode(input logic [VecW-1:0] vec,
                                           input logic [FamilyW-1:0] family);
    vec_info_t info;
    info = '{known: 1'b1, push: 1'b0, zero_code: 1'b0, restart: 1'b0};
    unique case (vec) inside
      VEC_DE, VEC_DB, VEC_BR, VEC_UD, VEC_NM, VEC_MF: info.restart = 1'b1;
      VEC_NMI, VEC_BP, VEC_OF: ;
      VEC_DF: begin
        info.push      = 1'b1;
        info.zero_code = 1'b1;
      end
      VEC_TS, VEC_NP, VEC_SS, VEC_GP, VEC_PF: begin
        info.push    = 1'b1;
        info.restart = 1'b1;
      end
      VEC_AC: begin
        info.known     = (family >= FAMILY_AC);
        info.push      = 1'b1;
        info.zero_code = 1'b1;
        info.restart   = 1'b1;
      end
      VEC_MC: begin
        info.known   = (family >= FAMILY_MC);
        info.restart = 1'b1;
      end
      VEC_XM: begin
        info.known   = (family >= FAMILY_XM);
        info.restart = 1'b1;
      end
      default: info.known = 1'b0;
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

### hdl/x86_exception_nesting_classifier_core.sv
// Top level of the exception nesting classifier: config, input stage, classify, result register.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_data_i (cpu family, 3 bits)
//  in      | in_valid_i/in_ready_o  | operation_i, vector_i, fault_code_i
//  out     | out_valid_o/out_ready_i| status_o, delivered_vector_o, push_error_o,
//          |                        | delivered_code_o, restart_previous_o
//
// One event per cycle unless a raise waits on a stalled result: an accepted beat sits in the
// input register, is classified against the nesting counter in one pass and, if a raise, lands
// in the result register on the next edge; a completion yields nothing.
// Reset clears the counter and both valid flags and sets the cpu family to 6; no sweep.
// A stalled result holds the input stage only when a raise is waiting behind it.
`timescale 1ns / 1ps
`default_nettype none

module x86_exception_nesting_classifier_core import xenc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [FamilyW-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               operation_i,
  input  wire logic [VecW-1:0]    vector_i,
  input  wire logic [CodeW-1:0]   fault_code_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [VecW-1:0]         delivered_vector_o,
  output logic                    push_error_o,
  output logic [CodeW-1:0]        delivered_code_o,
  output logic                    restart_previous_o
);

  logic [FamilyW-1:0] family_q;
  item_t              in_item, s1_item;
  logic               s1_valid;
  logic               advance;
  logic               out_free;
  result_t            result;
  result_t            out_q;
  logic               out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q <= FAMILY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      family_q <= cfg_data_i;
    end
  end

  assign in_item = '{op: op_e'(operation_i), vector: vector_i, code: fault_code_i};

  xenc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = s1_valid && (s1_item.op == OP_COMPLETE || out_free);

  xenc_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item),
    .family_i (family_q),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance && s1_item.op == OP_RAISE) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_item.op == OP_RAISE) begin
      out_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign delivered_vector_o = out_q.vector;
  assign push_error_o       = out_q.push;
  assign delivered_code_o   = out_q.code;
  assign restart_previous_o = out_q.restart;

endmodule

`default_nettype wire

### hdl/xenc_in_reg.sv
// Input register stage: holds one accepted event beat until it advances.
`timescale 1ns / 1ps
`default_nettype none

module xenc_in_reg import xenc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t item_i,
  input  wire logic  advance_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### hdl/xenc_classify.sv
// Nesting state and single-pass classification of one registered event.
`timescale 1ns / 1ps
`default_nettype none

module xenc_classify import xenc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire item_t               item_i,
  input  wire logic [FamilyW-1:0]  family_i,
  output result_t                  result_o
);

  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [VecW-1:0]   prev_q;
  logic              triple;
  logic              promote;
  logic              deliver;
  vec_info_t         info;
  class_e            prev_cls, cur_cls;

  always_comb begin
    count_inc = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 2'd1;
    triple    = (count_inc == COUNT_MAX) || (count_inc == COUNT_TWO && prev_q == VEC_DF);
    info      = vec_decode(item_i.vector, family_i);
    prev_cls  = vec_class(prev_q);
    cur_cls   = vec_class(item_i.vector);
    promote   = (count_inc >= COUNT_TWO) && PROMOTE[prev_cls][cur_cls];
    deliver   = !triple && info.known;

    result_o = '{status: STATUS_DELIVER, vector: '0, push: 1'b0, code: '0, restart: 1'b0};
    if (triple) begin
      result_o.status = STATUS_TRIPLE;
    end else if (!info.known) begin
      result_o.status = STATUS_UNKNOWN;
    end else begin
      result_o.restart = info.restart;
      if (promote) begin
        result_o.vector = VEC_DF;
        result_o.push   = 1'b1;
      end else begin
        result_o.vector = item_i.vector;
        result_o.push   = info.push;
        result_o.code   = (info.push && !info.zero_code) ? item_i.code : '0;
      end
    end

    count_d = count_q;
    if (step_i) begin
      count_d = (item_i.op == OP_COMPLETE) ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && item_i.op == OP_RAISE && deliver) begin
      prev_q <= result_o.vector;
    end
  end

  a_raise_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.op == OP_RAISE) |=> count_q != '0)
    else $error("nesting count zero after raise");

  a_complete_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.op == OP_COMPLETE) |=> count_q == '0)
    else $error("nesting count not cleared by completion");

  a_df_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.op == OP_RAISE && result_o.status == STATUS_DELIVER &&
     result_o.vector == VEC_DF) |-> (result_o.push && result_o.code == '0))
    else $error("double fault without zero pushed code");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.op == OP_RAISE && count_q == COUNT_MAX) |=> count_q == COUNT_MAX)
    else $error("nesting count wrapped");

endmodule

`default_nettype wire

### sim/exception_nesting_checker.sv
// Checker for the exception nesting classifier: predicts every raise and compares result beats.
`timescale 1ns / 1ps

module exception_nesting_checker import xenc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [FamilyW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               operation_i,
  input  logic [VecW-1:0]    vector_i,
  input  logic [CodeW-1:0]   fault_code_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         status_i,
  input  logic [VecW-1:0]    delivered_vector_i,
  input  logic               push_error_i,
  input  logic [CodeW-1:0]   delivered_code_i,
  input  logic               restart_previous_i,
  output int                 errors_o,
  output int                 pending_o
);

  logic [FamilyW-1:0] family;
  logic [CountW-1:0]  depth;
  logic [VecW-1:0]    last_delivered;
  result_t            expected_q[$];
  int                 fail_count = 0;

  function automatic class_e fault_class(input logic [VecW-1:0] vec);
    class_e cls;
    case (vec)
      VEC_DE, VEC_TS, VEC_NP, VEC_SS, VEC_GP: cls = CLS_CONTRIB;
      VEC_PF:                                 cls = CLS_PAGE;
      VEC_DF:                                 cls = CLS_DOUBLE;
      default:                                cls = CLS_BENIGN;
    endcase
    return cls;
  endfunction

  function automatic logic escalates(input class_e prior, input class_e cur_cls);
    logic hit;
    case (prior)
      CLS_BENIGN:  hit = (cur_cls == CLS_DOUBLE);
      CLS_CONTRIB: hit = (cur_cls == CLS_CONTRIB) || (cur_cls == CLS_DOUBLE);
      CLS_PAGE:    hit = (cur_cls != CLS_BENIGN);
      default:     hit = 1'b1;
    endcase
    return hit;
  endfunction

  function automatic result_t predict_raise(input logic [VecW-1:0] vec,
                                            input logic [CodeW-1:0] code);
    result_t         res;
    logic            known;
    logic            push;
    logic            restart;
    logic            clear_code;
    logic [VecW-1:0] out_vec;
    res        = '0;
    known      = 1'b1;
    push       = 1'b0;
    restart    = 1'b0;
    clear_code = 1'b0;
    out_vec    = vec;
    if (depth != COUNT_MAX) depth = depth + 1'b1;
    if (depth == COUNT_MAX || (depth == COUNT_TWO && last_delivered == VEC_DF)) begin
      res.status = STATUS_TRIPLE;
      return res;
    end
    case (vec)
      VEC_DE, VEC_DB, VEC_BR, VEC_UD, VEC_NM, VEC_MF: restart = 1'b1;
      VEC_NMI, VEC_BP, VEC_OF: ;
      VEC_DF: {push, clear_code} = 2'b11;
      VEC_TS, VEC_NP, VEC_SS, VEC_GP, VEC_PF: {push, restart} = 2'b11;
      VEC_AC: begin
        if (family >= FAMILY_AC) {push, clear_code, restart} = 3'b111;
        else known = 1'b0;
      end
      VEC_MC: begin
        if (family >= FAMILY_MC) restart = 1'b1;
        else known = 1'b0;
      end
      VEC_XM: begin
        if (family >= FAMILY_XM) restart = 1'b1;
        else known = 1'b0;
      end
      default: known = 1'b0;
    endcase
    if (!known) begin
      res.status = STATUS_UNKNOWN;
      return res;
    end
    if (depth == COUNT_TWO && escalates(fault_class(last_delivered), fault_class(vec))) begin
      out_vec    = VEC_DF;
      push       = 1'b1;
      clear_code = 1'b1;
    end
    last_delivered = out_vec;
    res.status  = STATUS_DELIVER;
    res.vector  = out_vec;
    res.push    = push;
    res.code    = (push && !clear_code) ? code : '0;
    res.restart = restart;
    return res;
  endfunction

  task automatic flag(input string what, input logic [CodeW-1:0] want,
                      input logic [CodeW-1:0] got);
    if (fail_count < 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      family         = FAMILY_RESET;
      depth          = '0;
      last_delivered = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) family = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: result beat with no raise pending, status %0d vector %0d",
                     $time, status_i, delivered_vector_i);
          end
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (status_i != want.status) begin
            flag("status", CodeW'(want.status), CodeW'(status_i));
          end
          if (delivered_vector_i != want.vector) begin
            flag("vector", CodeW'(want.vector), CodeW'(delivered_vector_i));
          end
          if (push_error_i != want.push) begin
            flag("push_error", CodeW'(want.push), CodeW'(push_error_i));
          end
          if (delivered_code_i != want.code) flag("code", want.code, delivered_code_i);
          if (restart_previous_i != want.restart) begin
            flag("restart", CodeW'(want.restart), CodeW'(restart_previous_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (operation_i == OP_COMPLETE) depth = '0;
        else expected_q.push_back(predict_raise(vector_i, fault_code_i));
      end
    end
    pending_o <= expected_q.size();
    errors_o  <= fail_count;
  end

endmodule

### sim/tb.sv
// Testbench top for the exception nesting classifier: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import xenc_pkg::*;

  localparam logic [FamilyW-1:0] FAMILY_MIN = 3'd3;
  localparam int RESULT_LATENCY = 2;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_LIMIT     = 2000;
  localparam int PHASE_ITEMS    = 125;

  localparam logic [VecW-1:0] VEC_RSVD9      = 5'd9;
  localparam logic [VecW-1:0] VEC_RSVD15     = 5'd15;
  localparam logic [VecW-1:0] VEC_FIRST_RSVD = 5'd20;

  localparam logic [FamilyW-1:0] FAMILY_PLAN [8] = '{
    FAMILY_AC, FAMILY_MC, FAMILY_XM, FAMILY_MIN, FAMILY_MC, FAMILY_AC, FAMILY_XM, FAMILY_MIN
  };
  localparam logic [VecW-1:0] FAULT_PICK [12] = '{
    VEC_DE, VEC_DB, VEC_NMI, VEC_BP, VEC_BR, VEC_DF, VEC_TS, VEC_GP, VEC_PF, VEC_MF,
    VEC_AC, VEC_XM
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [FamilyW-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               operation;
  logic [VecW-1:0]    vector;
  logic [CodeW-1:0]   fault_code;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [VecW-1:0]    delivered_vector;
  logic               push_error;
  logic [CodeW-1:0]   delivered_code;
  logic               restart_previous;
  int                 errors;
  int                 pending;

  bit src_pace;
  bit sink_pace;
  bit sink_hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  x86_exception_nesting_classifier_core uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .operation_i        (operation),
    .vector_i           (vector),
    .fault_code_i       (fault_code),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .status_o           (status),
    .delivered_vector_o (delivered_vector),
    .push_error_o       (push_error),
    .delivered_code_o   (delivered_code),
    .restart_previous_o (restart_previous)
  );

  exception_nesting_checker nesting_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .operation_i        (operation),
    .vector_i           (vector),
    .fault_code_i       (fault_code),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .status_i           (status),
    .delivered_vector_i (delivered_vector),
    .push_error_i       (push_error),
    .delivered_code_i   (delivered_code),
    .restart_previous_i (restart_previous),
    .errors_o           (errors),
    .pending_o          (pending)
  );

  function automatic logic [VecW-1:0] pick_vector();
    logic [VecW-1:0] vec;
    if ($urandom_range(0, 3) == 0) vec = VecW'($urandom_range(0, 31));
    else vec = FAULT_PICK[$urandom_range(0, 11)];
    return vec;
  endfunction

  function automatic logic [CodeW-1:0] pick_code();
    logic [CodeW-1:0] code;
    case ($urandom_range(0, 7))
      0:       code = '0;
      1:       code = '1;
      default: code = $urandom;
    endcase
    return code;
  endfunction

  task automatic push_event(input op_e op, input logic [VecW-1:0] vec,
                            input logic [CodeW-1:0] code);
    int gap;
    gap = src_pace ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    vector     <= vec;
    fault_code <= code;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic write_family(input logic [FamilyW-1:0] fam);
    cfg_valid <= 1'b1;
    cfg_data  <= fam;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned items, input bit paced);
    int unsigned sent;
    int unsigned episodes;
    int unsigned chain;
    int unsigned roll;
    sent     = 0;
    episodes = 0;
    src_pace = paced;
    while (sent < items) begin
      if (paced && episodes % 8 == 0) src_pace = ($urandom_range(0, 2) != 0);
      roll  = $urandom_range(0, 15);
      chain = (roll < 12) ? $urandom_range(1, 2) : $urandom_range(3, 5);
      if (roll == 0) begin
        push_event(OP_COMPLETE, pick_vector(), pick_code());
        sent++;
      end
      repeat (chain) push_event(OP_RAISE, pick_vector(), pick_code());
      sent += chain;
      // leave the chain open now and then so the next one nests deeper
      if (roll != 15) begin
        push_event(OP_COMPLETE, pick_vector(), pick_code());
        sent++;
      end
      episodes++;
      if ($urandom_range(0, 47) == 0) wait_results_drained();
    end
  endtask

  initial begin : sink
    int stall;
    int beats;
    beats = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (beats % 32 == 0) sink_pace = ($urandom_range(0, 2) != 0);
      if (sink_hold_req) begin
        stall = HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end else begin
        stall = sink_pace ? $urandom_range(0, 19) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= FAMILY_RESET;
    in_valid   <= 1'b0;
    operation  <= OP_RAISE;
    vector     <= '0;
    fault_code <= '0;
    src_pace      = 1'b1;
    sink_hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // completion with nothing nested, then deliver before any nested raise
    push_event(OP_COMPLETE, VEC_DE, '0);
    push_event(OP_RAISE, VEC_DE, 32'hFFFF_FFFF);
    push_event(OP_RAISE, VEC_PF, 32'hAAAA_AAAA);
    push_event(OP_RAISE, VEC_GP, 32'h0000_0001);
    push_event(OP_RAISE, VEC_BP, 32'h8000_0000);
    push_event(OP_COMPLETE, VEC_PF, 32'hFFFF_FFFF);
    push_event(OP_RAISE, VEC_PF, 32'h5555_5555);
    push_event(OP_RAISE, VEC_PF, 32'h0000_0000);
    push_event(OP_COMPLETE, VEC_DF, '0);
    push_event(OP_RAISE, VEC_DF, 32'h1234_5678);
    push_event(OP_RAISE, VEC_DB, 32'hFFFF_FFFF);
    push_event(OP_COMPLETE, VEC_DB, '0);
    push_event(OP_RAISE, VEC_AC, 32'hFFFF_FFFF);
    push_event(OP_RAISE, VEC_RSVD15, 32'hDEAD_BEEF);
    push_event(OP_COMPLETE, VEC_AC, '0);
    push_event(OP_RAISE, 5'd31, 32'hFFFF_FFFF);
    push_event(OP_RAISE, VEC_XM, 32'h0F0F_0F0F);
    push_event(OP_COMPLETE, VEC_XM, '0);
    push_event(OP_RAISE, VEC_MC, 32'hF0F0_F0F0);
    push_event(OP_RAISE, VEC_RSVD9, 32'h0000_FFFF);
    push_event(OP_RAISE, VEC_FIRST_RSVD, 32'hFFFF_0000);

    wait_results_drained();
    write_family(FAMILY_MIN);
    push_event(OP_COMPLETE, VEC_DE, '0);
    push_event(OP_RAISE, VEC_AC, 32'hFFFF_FFFF);
    push_event(OP_RAISE, VEC_MC, 32'h0000_0000);
    push_event(OP_COMPLETE, VEC_MC, '0);
    push_event(OP_RAISE, VEC_XM, 32'h1111_1111);

    for (int phase = 0; phase < 8; phase++) begin
      wait_results_drained();
      write_family(FAMILY_PLAN[phase]);
      if (phase == 2) begin
        // stall the result side and keep offering beats until the input backs up
        sink_hold_req = 1'b1;
        run_random(60, 1'b0);
      end
      run_random(PHASE_ITEMS, 1'b1);
    end

    wait_results_drained();
    repeat (2 * RESULT_LATENCY) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
